[sv/crc32c_frame_checker_assert.svh]
`ifndef CRC32C_FRAME_CHECKER_ASSERT_SVH
`define CRC32C_FRAME_CHECKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define C32FC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("c32fc assertion failed");

// next-cycle implication, checked outside reset
`define C32FC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("c32fc assertion failed");

`endif

[sv/c32fc_pkg.sv]
package c32fc_pkg;

    localparam int HDR_LEN      = 24;
    localparam int HDR_CRC_SPAN = 20;
    localparam int HDR_IDX_W    = $clog2(HDR_LEN);
    localparam int CNT_W        = 25;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int MAX_PAY_W    = 24;

    localparam int OFS_MAGIC   = 0;
    localparam int OFS_VERSION = 4;
    localparam int OFS_TYPE    = 6;
    localparam int OFS_SEQ     = 8;
    localparam int OFS_LEN     = 12;
    localparam int OFS_PCRC    = 16;
    localparam int OFS_HCRC    = 20;

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [MAX_PAY_W-1:0] MAX_PAYLOAD_RST = 24'd65536;
    localparam logic [31:0]          FRAME_MAGIC_RST = 32'd0;
    localparam logic [15:0]          PROTO_VER_RST   = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_PAYLOAD      = 2'd0,
        CFG_FRAME_MAGIC      = 2'd1,
        CFG_PROTOCOL_VERSION = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_OVERSIZED       = 3'd1,
        ST_BAD_MAGIC       = 3'd2,
        ST_BAD_HDR_CRC     = 3'd3,
        ST_BAD_VERSION     = 3'd4,
        ST_BAD_PAYLOAD_CRC = 3'd5
    } t_status;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        t_status     status;
        logic [15:0] message_type;
        logic [31:0] sequence_res;
        logic [31:0] announced_len;
    } t_result;

    // reflected crc-32c, one byte
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[sv/c32fc_in_if.sv]
interface c32fc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

[sv/c32fc_out_if.sv]
interface c32fc_out_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic [2:0]  status;
    logic [15:0] message_type;
    logic [31:0] sequence_res;
    logic [31:0] announced_len;

    modport source (
        output valid, output payload_valid, output payload_byte, output frame_done,
        output status, output message_type, output sequence_res, output announced_len,
        input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input frame_done,
        input status, input message_type, input sequence_res, input announced_len,
        output ready
    );
endinterface

[sv/crc32c_frame_checker.sv]
// Frame checker for a byte stream of length-prefixed frames: a 24-byte little-endian
// header (magic, version, type, sequence, payload length, payload crc-32c, header crc-32c
// over bytes 0..19) followed by the payload. Header bytes give no output beat; each payload
// byte gives one beat with payload_valid set, and the beat of the last byte (or of the last
// header byte for an empty or oversized payload) also carries frame_done, the status and the
// header fields. Status is the first failing check: oversized (length above max_payload,
// decided when the header completes), bad magic, bad header crc, bad version, bad payload
// crc. After an error every byte is taken and dropped until reset. The block takes one byte
// every cycle while beats are taken; an accepted byte waits in the input register, which feeds
// the byte-wise crc-32c update and header checks straight into the output register once the
// output can take a beat. While a beat waits at the output, one more byte is held in the
// input register and then the input stalls.
// Configuration writes take effect on the next cycle; max_payload is sampled when a header
// completes, frame_magic and protocol_version when a frame ends.
`include "crc32c_frame_checker_assert.svh"

module crc32c_frame_checker
    import c32fc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    c32fc_in_if.sink              i_byte_ch,
    c32fc_out_if.source           o_res_ch
);

    logic [MAX_PAY_W-1:0] r_max_payload;
    logic [31:0]          r_frame_magic;
    logic [15:0]          r_proto_ver;

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;

    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_end_cnt, n_end_cnt;
    logic [7:0]           r_hdr [HDR_LEN];
    logic [7:0]           n_hdr [HDR_LEN];
    logic [31:0]          r_hcrc, n_hcrc;
    logic [31:0]          r_pcrc, n_pcrc;
    logic                 r_closed, n_closed;

    logic                 r_out_valid;
    t_result              r_out, n_out;

    logic                 s_go;
    logic                 s_step;
    logic                 s_in_hdr;
    logic                 s_emit;
    logic                 s_restart;
    logic [31:0]          s_len;
    t_status              s_final;

    assign s_go             = !r_out_valid || o_res_ch.ready;
    assign s_step           = r_in_valid && s_go && !r_closed;
    assign s_in_hdr         = r_cnt < CNT_W'(HDR_LEN);
    assign i_byte_ch.ready  = !r_in_valid || s_go;

    // header capture and crc datapath
    always_comb begin
        n_hdr  = r_hdr;
        n_hcrc = r_hcrc;
        n_pcrc = r_pcrc;
        if (s_step) begin
            if (s_in_hdr) begin
                n_hdr[r_cnt[HDR_IDX_W-1:0]] = r_in_byte;
                if (r_cnt < CNT_W'(HDR_CRC_SPAN)) begin
                    n_hcrc = crc32c_byte(r_hcrc, r_in_byte);
                end
            end else begin
                n_pcrc = crc32c_byte(r_pcrc, r_in_byte);
            end
        end
    end

    // frame checks, first failure wins
    always_comb begin
        s_len = {n_hdr[OFS_LEN+3], n_hdr[OFS_LEN+2], n_hdr[OFS_LEN+1], n_hdr[OFS_LEN]};
        if ({n_hdr[OFS_MAGIC+3], n_hdr[OFS_MAGIC+2], n_hdr[OFS_MAGIC+1], n_hdr[OFS_MAGIC]}
                != r_frame_magic) begin
            s_final = ST_BAD_MAGIC;
        end else if (~n_hcrc != {n_hdr[OFS_HCRC+3], n_hdr[OFS_HCRC+2], n_hdr[OFS_HCRC+1],
                                  n_hdr[OFS_HCRC]}) begin
            s_final = ST_BAD_HDR_CRC;
        end else if ({n_hdr[OFS_VERSION+1], n_hdr[OFS_VERSION]} != r_proto_ver) begin
            s_final = ST_BAD_VERSION;
        end else if (~n_pcrc != {n_hdr[OFS_PCRC+3], n_hdr[OFS_PCRC+2], n_hdr[OFS_PCRC+1],
                                  n_hdr[OFS_PCRC]}) begin
            s_final = ST_BAD_PAYLOAD_CRC;
        end else begin
            s_final = ST_OK;
        end
    end

    // frame sequencing and result beat
    always_comb begin
        n_cnt     = r_cnt;
        n_end_cnt = r_end_cnt;
        n_closed  = r_closed;
        s_emit    = 1'b0;
        s_restart = 1'b0;
        n_out     = '0;
        if (s_step) begin
            n_cnt = r_cnt + CNT_W'(1);
            if (s_in_hdr) begin
                if (r_cnt == CNT_W'(HDR_LEN - 1)) begin
                    n_end_cnt = CNT_W'(HDR_LEN) + s_len[CNT_W-1:0];
                    if (s_len > {8'd0, r_max_payload}) begin
                        s_emit           = 1'b1;
                        n_out.frame_done = 1'b1;
                        n_out.status     = ST_OVERSIZED;
                    end else if (s_len == 32'd0) begin
                        s_emit           = 1'b1;
                        n_out.frame_done = 1'b1;
                        n_out.status     = s_final;
                    end
                end
            end else begin
                s_emit              = 1'b1;
                n_out.payload_valid = 1'b1;
                n_out.payload_byte  = r_in_byte;
                if (n_cnt == r_end_cnt) begin
                    n_out.frame_done = 1'b1;
                    n_out.status     = s_final;
                end
            end
            if (n_out.frame_done) begin
                n_out.message_type  = {n_hdr[OFS_TYPE+1], n_hdr[OFS_TYPE]};
                n_out.sequence_res  = {n_hdr[OFS_SEQ+3], n_hdr[OFS_SEQ+2],
                                       n_hdr[OFS_SEQ+1], n_hdr[OFS_SEQ]};
                n_out.announced_len = s_len;
                if (n_out.status != ST_OK) begin
                    n_closed = 1'b1;
                end else begin
                    s_restart = 1'b1;
                    n_cnt     = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_frame_magic <= FRAME_MAGIC_RST;
            r_proto_ver   <= PROTO_VER_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAX_PAYLOAD:      r_max_payload <= i_cfg_data[MAX_PAY_W-1:0];
                CFG_FRAME_MAGIC:      r_frame_magic <= i_cfg_data;
                CFG_PROTOCOL_VERSION: r_proto_ver   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_end_cnt   <= '0;
            r_hcrc      <= CRC_INIT;
            r_pcrc      <= CRC_INIT;
            r_closed    <= 1'b0;
        end else begin
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                r_in_valid <= 1'b1;
            end else if (r_in_valid && s_go) begin
                r_in_valid <= 1'b0;
            end
            if (s_step && s_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            r_cnt     <= n_cnt;
            r_end_cnt <= n_end_cnt;
            r_hcrc    <= s_restart ? CRC_INIT : n_hcrc;
            r_pcrc    <= s_restart ? CRC_INIT : n_pcrc;
            r_closed  <= n_closed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_ch.valid && i_byte_ch.ready) begin
            r_in_byte <= i_byte_ch.data_byte;
        end
        if (s_step && s_emit) begin
            r_out <= n_out;
        end
        r_hdr <= n_hdr;
    end

    assign o_res_ch.valid          = r_out_valid;
    assign o_res_ch.payload_valid  = r_out.payload_valid;
    assign o_res_ch.payload_byte   = r_out.payload_byte;
    assign o_res_ch.frame_done     = r_out.frame_done;
    assign o_res_ch.status         = r_out.status;
    assign o_res_ch.message_type   = r_out.message_type;
    assign o_res_ch.sequence_res   = r_out.sequence_res;
    assign o_res_ch.announced_len  = r_out.announced_len;

    `C32FC_ASSERT_NEXT(a_closed_silent, i_clk, i_rst_n, r_closed && !r_out_valid, !r_out_valid)
    `C32FC_ASSERT_NOW(a_status_only_at_end, i_clk, i_rst_n,
        r_out_valid && !r_out.frame_done, r_out.status == ST_OK)
    `C32FC_ASSERT_NEXT(a_error_closes, i_clk, i_rst_n,
        s_step && s_emit && n_out.frame_done && n_out.status != ST_OK, r_closed)
    `C32FC_ASSERT_NOW(a_payload_in_bounds, i_clk, i_rst_n,
        !r_closed && !s_in_hdr, r_cnt < r_end_cnt)

endmodule
